// ===== hdl/ulid_monotonic_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// ULID generator assertion macros
// Shorthand for the clocked, reset-qualified checks used in the core.
// ----------------------------------------------------------------------------
`ifndef ULID_MONOTONIC_GENERATOR_CORE_MACROS_SVH
`define ULID_MONOTONIC_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define ULID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ULID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ulid_pkg.sv =====
// ----------------------------------------------------------------------------
// ULID generator package
// Widths, the identifier word layout and the Crockford base-32 alphabet.
// ----------------------------------------------------------------------------
package ulid_pkg;

  localparam int TIME_W      = 50;
  localparam int HALF_W      = 40;
  localparam int RAND_W      = 80;
  localparam int DIGIT_W     = 5;
  localparam int CHAR_W      = 7;
  localparam int ID_LEN      = 26;
  localparam int POS_W       = 5;
  localparam int WORD_W      = TIME_W + RAND_W;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 8;

  // time in the upper bits, random part below, both most significant digit first
  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [RAND_W-1:0] rnd;
  } id_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] pos;
  } bk_stat_t;

  localparam logic [CHAR_W-1:0] ALPHABET [0:31] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
    7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

endpackage

// ===== hdl/ulid_front.sv =====
// ----------------------------------------------------------------------------
// ULID front end
// Takes input items, applies the monotonic rule and pushes the 130-bit word.
// ----------------------------------------------------------------------------
module ulid_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        accept,
  input  logic [ulid_pkg::TIME_W-1:0] now_ms,
  input  logic [ulid_pkg::HALF_W-1:0] random_high,
  input  logic [ulid_pkg::HALF_W-1:0] random_low,
  output ulid_pkg::id_word_t          push_word
);

  logic                        mono_r;
  logic [ulid_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic [ulid_pkg::RAND_W-1:0] rnd_r, rnd_nxt;
  logic [ulid_pkg::RAND_W-1:0] rnd_in, rnd_inc;
  logic                        later;

  assign rnd_in  = {random_high, random_low};
  assign rnd_inc = rnd_r + ulid_pkg::RAND_W'(1);
  assign later   = now_ms > last_time_r;

  always_comb begin
    last_time_nxt = last_time_r;
    rnd_nxt       = rnd_r;
    push_word.ts  = now_ms;
    push_word.rnd = rnd_in;
    if (mono_r) begin
      if (later) begin
        last_time_nxt = now_ms;
        rnd_nxt       = rnd_in;
      end else begin
        // same or earlier millisecond: reuse time, bump random part
        rnd_nxt       = rnd_inc;
        push_word.ts  = last_time_r;
        push_word.rnd = rnd_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r      <= 1'b1;
      last_time_r <= '0;
      rnd_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        mono_r <= cfg_wr_data;
      end
      if (accept) begin
        last_time_r <= last_time_nxt;
        rnd_r       <= rnd_nxt;
      end
    end
  end

endmodule

// ===== hdl/ulid_queue.sv =====
// ----------------------------------------------------------------------------
// ULID word queue
// Short first-in first-out queue between front end and serializer.
// ----------------------------------------------------------------------------
module ulid_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ulid_pkg::id_word_t push_word,
  input  logic               pop,
  output ulid_pkg::id_word_t pop_word,
  output ulid_pkg::q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ulid_pkg::id_word_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign stat.full  = cnt_r == CNT_W'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign pop_word   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/ulid_back.sv =====
// ----------------------------------------------------------------------------
// ULID serializer
// Emits the 26 characters of each word, one per cycle while out_tready is high, through an output register.
// ----------------------------------------------------------------------------
module ulid_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ulid_pkg::q_stat_t             qstat,
  input  ulid_pkg::id_word_t            pop_word,
  output logic                          pop,
  output ulid_pkg::bk_stat_t            stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ulid_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_tlast
);

  logic [ulid_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                        busy_r, busy_nxt;
  logic [ulid_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                        tvalid_r;
  logic [ulid_pkg::CHAR_W-1:0] char_r;
  logic                        last_r;
  logic                        slot_free, advance, is_last;

  assign slot_free = !tvalid_r || out_tready;
  assign advance   = busy_r && slot_free;
  assign is_last   = pos_r == ulid_pkg::POS_W'(ulid_pkg::ID_LEN - 1);
  // take the next word as soon as the last character of this one moves out
  assign pop       = !qstat.empty && (!busy_r || (advance && is_last));

  always_comb begin
    word_nxt = word_r;
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (pop) begin
      word_nxt = pop_word;
      busy_nxt = 1'b1;
      pos_nxt  = '0;
    end else if (advance) begin
      word_nxt = word_r << ulid_pkg::DIGIT_W;
      busy_nxt = !is_last;
      pos_nxt  = pos_r + ulid_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (advance) begin
      char_r <= ulid_pkg::ALPHABET[word_r[ulid_pkg::WORD_W-1 -: ulid_pkg::DIGIT_W]];
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pos_r    <= '0;
      tvalid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      if (advance) begin
        tvalid_r <= 1'b1;
      end else if (out_tready) begin
        tvalid_r <= 1'b0;
      end
    end
  end

  assign stat.busy  = busy_r;
  assign stat.pos   = pos_r;
  assign out_tvalid = tvalid_r;
  assign out_char   = char_r;
  assign out_tlast  = last_r;

endmodule

// ===== hdl/ulid_monotonic_generator_core.sv =====
// ----------------------------------------------------------------------------
// ULID monotonic generator core
// Turns a millisecond time and 80 random bits into a 26-character ULID.
// ----------------------------------------------------------------------------
// Input channel in_*: one item per identifier (time and two random halves).
// Output channel out_*: 26 ASCII characters per item, time digits first,
// out_tlast high on the 26th. cfg_wr_en/cfg_wr_data write monotonic_mode;
// write it only while no item is in flight.
// Path: an item taken on the input reaches the output through the queue
// write, then the serializer load, then the output register. Throughput:
// one character per cycle while out_tready is high, set by the single
// serializer; the queue takes new items while the serializer is busy.
// The front end takes items into a QUEUE_DEPTH-entry queue; in_tready drops
// only when that queue is full.
// Reset (rst_n low, synchronous): queue and serializer empty, stored time and
// random digits zero, monotonic mode on.
// When the receiver holds out_tready low, the current character stays on the
// output, the serializer pauses, the queue fills and then in_tready falls.
// ----------------------------------------------------------------------------
`include "ulid_monotonic_generator_core_macros.svh"

module ulid_monotonic_generator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_wr_data,  // monotonic_mode
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // now_ms[49:0], random_high[89:50], random_low[129:90], zero pad
  input  logic [ulid_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // id_char[6:0], zero pad
  output logic [ulid_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast     // last_char
);

  localparam int RH_LO = ulid_pkg::TIME_W;
  localparam int RL_LO = ulid_pkg::TIME_W + ulid_pkg::HALF_W;
  localparam logic [ulid_pkg::POS_W-1:0] POS_END = ulid_pkg::POS_W'(ulid_pkg::ID_LEN);

  ulid_pkg::id_word_t          push_word, pop_word;
  ulid_pkg::q_stat_t           qstat;
  ulid_pkg::bk_stat_t          bstat;
  logic                        accept, pop;
  logic [ulid_pkg::CHAR_W-1:0] out_char;
  logic [ulid_pkg::OUT_TDATA_W+1:0] out_bus;

  assign in_tready = !qstat.full;
  assign accept    = in_tvalid && in_tready;

  ulid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .now_ms      (in_tdata[ulid_pkg::TIME_W-1:0]),
    .random_high (in_tdata[RH_LO +: ulid_pkg::HALF_W]),
    .random_low  (in_tdata[RL_LO +: ulid_pkg::HALF_W]),
    .push_word   (push_word)
  );

  ulid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (qstat)
  );

  ulid_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .pop_word   (pop_word),
    .pop        (pop),
    .stat       (bstat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {{(ulid_pkg::OUT_TDATA_W - ulid_pkg::CHAR_W){1'b0}}, out_char};
  assign out_bus   = {out_tvalid, out_tlast, out_tdata};

  `ULID_ASSERT_IMP(a_pos_range, bstat.busy, bstat.pos < POS_END, "position out of range")
  `ULID_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")
  `ULID_ASSERT_NXT(a_no_phantom, qstat.empty && !bstat.busy && !out_tvalid, !out_tvalid, "stray item")
  `ULID_ASSERT_NXT(a_hold_stall, out_tvalid && !out_tready, $stable(out_bus), "item changed in stall")

endmodule
